// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define ASSERT_OFF to drop
// them from a build.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent true implies consequent true in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// expression must never be true
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/bb33_pkg.sv =====
// ---------------------------------------------------------------------------
// bb33_pkg
// Shared constants and types of the 3x3 RGBA box blur.
// ---------------------------------------------------------------------------
package bb33_pkg;

	localparam int unsigned MAX_SIZE_DEF     = 1024;
	localparam int unsigned CHANNEL_BITS_DEF = 16;
	localparam int unsigned IMAGE_SIZE_RESET = 1024;

	localparam int unsigned CFG_W = 11;  // image_size register
	localparam int unsigned CH_W  = 16;  // channel ports
	localparam int unsigned POS_W = 10;  // out_row / out_column

	// divisor of the clipped window: corner, edge, interior
	typedef enum logic [1:0] {
		DIV4,
		DIV6,
		DIV9
	} div_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} pos_t;

	// one output beat request: which window taps to sum and how to divide
	typedef struct packed {
		logic       valid;
		logic [2:0] row_en;
		logic [2:0] col_en;
		div_t       div;
		pos_t       pos;
	} emit_t;

endpackage

// ===== hw/rtl/bb33_mean.sv =====
// ---------------------------------------------------------------------------
// bb33_mean
// Masked 3x3 window sum and divide by 4, 6 or 9 through a reciprocal
// multiply. Three register stages, all advanced by one enable.
// ---------------------------------------------------------------------------
module bb33_mean #(
	parameter int unsigned CHANNEL_BITS = bb33_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  bb33_pkg::emit_t                           rec,
	input  logic [4*CHANNEL_BITS-1:0]                 win [3][3],
	output logic                                      beat_valid,
	output bb33_pkg::pos_t                            beat_pos,
	output logic [3:0][bb33_pkg::CH_W-1:0]            beat_ch
);

	localparam int unsigned CB   = CHANNEL_BITS;
	localparam int unsigned RW   = CB + 2;        // sum of three taps
	localparam int unsigned SUMW = CB + 4;        // sum of nine taps
	localparam int unsigned PRW  = 2 * SUMW + 1;  // product width

	// ceil(2^(SUMW+l)/d) with 2^l >= d gives exact floor division for sums below 2^SUMW
	localparam logic [63:0] R4_W = 64'd1 << SUMW;
	localparam logic [63:0] R6_W = ((64'd1 << (SUMW + 3)) + 64'd5) / 64'd6;
	localparam logic [63:0] R9_W = ((64'd1 << (SUMW + 4)) + 64'd8) / 64'd9;
	localparam int unsigned SH4 = SUMW + 2;
	localparam int unsigned SH6 = SUMW + 3;
	localparam int unsigned SH9 = SUMW + 4;

	logic                 valid_s3, valid_s4, valid_s5;
	bb33_pkg::pos_t       pos_s3, pos_s4, pos_s5;
	bb33_pkg::div_t       div_s3, div_s4, div_s5;
	logic [RW-1:0]        rsum_s3 [3][4];
	logic [SUMW-1:0]      sum_s4 [4];
	logic [PRW-1:0]       prod_s5 [4];

	logic [RW-1:0]        rsum_n [3][4];
	logic [SUMW:0]        recip;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int ch = 0; ch < 4; ch++) begin
				rsum_n[k][ch] = '0;
				for (int m = 0; m < 3; m++) begin
					if (rec.row_en[k] && rec.col_en[m])
						rsum_n[k][ch] = rsum_n[k][ch] + RW'(win[k][m][ch*CB +: CB]);
				end
			end
		end
	end

	always_comb begin
		case (div_s4)
			bb33_pkg::DIV6: recip = R6_W[SUMW:0];
			bb33_pkg::DIV9: recip = R9_W[SUMW:0];
			default:        recip = R4_W[SUMW:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= rec.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s3 <= rec.pos;
			div_s3 <= rec.div;
			rsum_s3 <= rsum_n;
			pos_s4 <= pos_s3;
			div_s4 <= div_s3;
			pos_s5 <= pos_s4;
			div_s5 <= div_s4;
			for (int ch = 0; ch < 4; ch++) begin
				sum_s4[ch] <= SUMW'(rsum_s3[0][ch]) + SUMW'(rsum_s3[1][ch])
					+ SUMW'(rsum_s3[2][ch]);
				prod_s5[ch] <= PRW'(sum_s4[ch]) * PRW'(recip);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			case (div_s5)
				bb33_pkg::DIV6: beat_ch[ch] = bb33_pkg::CH_W'(prod_s5[ch] >> SH6);
				bb33_pkg::DIV9: beat_ch[ch] = bb33_pkg::CH_W'(prod_s5[ch] >> SH9);
				default:        beat_ch[ch] = bb33_pkg::CH_W'(prod_s5[ch] >> SH4);
			endcase
		end
	end

	assign beat_valid = valid_s5;
	assign beat_pos   = pos_s5;

endmodule

// ===== hw/rtl/box_blur_3x3_rgba_top.sv =====
// ---------------------------------------------------------------------------
// box_blur_3x3_rgba_top
// Streaming 3x3 mean filter for a square RGBA image with clipped borders.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels of a square image enter in raster order on the pix channel
//   (valid/ready), action low. After the last pixel, send image_size beats
//   with action high to push out the final row. Each pixel beat at (r, c)
//   releases the mean at (r-1, c-1); the last pixel of a row also releases
//   (r-1, size-1). Pixels sent while flushing, and flush beats sent while not
//   flushing, are taken and dropped.
//   image_size is written through cfg_we/cfg_wdata while the block is idle;
//   a write also restarts the frame.
// Timing:
//   A result passes stage 1, stage 2, the bb33_mean stages and the output
//   register to res_valid; the second result of a row end follows the first.
//   One beat per cycle is taken while the skid is empty; a beat that releases
//   two results holds pix_ready low while the second is issued. The single row
//   memory: read at accept, write-back from stage 1, at different entries.
// Reset and stall:
//   Reset sets image_size to 1024 and clears counters and pipeline valids.
//   The row memory is not cleared; entries are written before use.
//   When res_ready is low a one-beat skid catches the last result and the
//   whole pipeline freezes the cycle after, dropping pix_ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module box_blur_3x3_rgba_top #(
	parameter int unsigned MAX_SIZE     = bb33_pkg::MAX_SIZE_DEF,
	parameter int unsigned CHANNEL_BITS = bb33_pkg::CHANNEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bb33_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  logic                          action,
	input  logic [bb33_pkg::CH_W-1:0]     red_in,
	input  logic [bb33_pkg::CH_W-1:0]     green_in,
	input  logic [bb33_pkg::CH_W-1:0]     blue_in,
	input  logic [bb33_pkg::CH_W-1:0]     alpha_in,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [bb33_pkg::CH_W-1:0]     red_out,
	output logic [bb33_pkg::CH_W-1:0]     green_out,
	output logic [bb33_pkg::CH_W-1:0]     blue_out,
	output logic [bb33_pkg::CH_W-1:0]     alpha_out,
	output logic [bb33_pkg::POS_W-1:0]    out_row,
	output logic [bb33_pkg::POS_W-1:0]    out_column,
	output logic                          frame_end
);

	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned PW = 4 * CB;
	localparam int unsigned CW = $clog2(MAX_SIZE);
	localparam int unsigned SW = $clog2(MAX_SIZE + 1);
	localparam int unsigned SIZE_RST =
		(bb33_pkg::IMAGE_SIZE_RESET > MAX_SIZE) ? MAX_SIZE : bb33_pkg::IMAGE_SIZE_RESET;

	// frame control
	logic [SW-1:0]    size_q, row_q;
	logic [CW-1:0]    col_q;
	logic             flushing_q;

	// stage 1: accepted beat, row memory read data
	logic             valid_s1, flush_s1;
	logic [CW-1:0]    c_s1;
	logic [PW-1:0]    pix_s1;
	logic [2*PW-1:0]  rd_s1;
	bb33_pkg::emit_t  rec1_s1, rec2_s1;

	// stage 2: window and result request
	logic [PW-1:0]    win_q [3][3];
	bb33_pkg::emit_t  rec_s2, rec2_q;
	logic             pend2_q;

	// row memory: upper half holds row r-2, lower half row r-1
	logic [2*PW-1:0]  row_mem [MAX_SIZE];

	// output register and skid
	logic                            skid_valid_q;
	bb33_pkg::pos_t                  skid_pos_q;
	logic [3:0][bb33_pkg::CH_W-1:0]  skid_ch_q;

	logic             beat_valid;
	bb33_pkg::pos_t   beat_pos;
	logic [3:0][bb33_pkg::CH_W-1:0] beat_ch;

	logic             en, s1_adv, acc, eff0, mem_re, mem_we;
	logic [SW-1:0]    r0, c0_ext, size_m1;
	logic             k0v, k2v, c2, rows3, emit1, lastc0;
	bb33_pkg::emit_t  rec1_n, rec2_n, rec1_go;
	logic [PW-1:0]    pix_n;
	logic [SW-1:0]    size_n;
	logic [31:0]      wd32;

	assign en        = !skid_valid_q;
	assign s1_adv    = en && !pend2_q;
	assign pix_ready = s1_adv;
	assign acc       = pix_valid && pix_ready;

	// ---- stage 0: classify the beat and build its result requests
	always_comb begin
		size_m1 = size_q - SW'(1);
		r0      = action ? size_q : row_q;
		c0_ext  = SW'(col_q);
		eff0    = (action == flushing_q);
		k0v     = r0 >= SW'(2);
		k2v     = r0 != size_q;
		c2      = c0_ext >= SW'(2);
		rows3   = k0v && k2v;
		emit1   = (r0 != '0) && (col_q != '0);
		lastc0  = c0_ext == size_m1;

		rec1_n.valid    = emit1;
		rec1_n.row_en   = {k2v, 1'b1, k0v};
		rec1_n.col_en   = {2'b11, c2};
		rec1_n.div      = (rows3 && c2) ? bb33_pkg::DIV9 :
			((rows3 || c2) ? bb33_pkg::DIV6 : bb33_pkg::DIV4);
		rec1_n.pos.row  = bb33_pkg::POS_W'(r0 - SW'(1));
		rec1_n.pos.col  = bb33_pkg::POS_W'(c0_ext - SW'(1));
		rec1_n.pos.last = 1'b0;

		rec2_n.valid    = emit1 && lastc0;
		rec2_n.row_en   = {k2v, 1'b1, k0v};
		rec2_n.col_en   = 3'b110;
		rec2_n.div      = rows3 ? bb33_pkg::DIV6 : bb33_pkg::DIV4;
		rec2_n.pos.row  = bb33_pkg::POS_W'(r0 - SW'(1));
		rec2_n.pos.col  = bb33_pkg::POS_W'(c0_ext);
		rec2_n.pos.last = r0 == size_q;

		pix_n = action ? '0 :
			{alpha_in[CB-1:0], blue_in[CB-1:0], green_in[CB-1:0], red_in[CB-1:0]};
	end

	// clamp the written size into 2..MAX_SIZE
	always_comb begin
		wd32 = 32'(cfg_wdata);
		if (wd32 < 32'd2)
			size_n = SW'(2);
		else if (wd32 > 32'(MAX_SIZE))
			size_n = SW'(MAX_SIZE);
		else
			size_n = SW'(wd32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= SW'(SIZE_RST);
			row_q      <= '0;
			col_q      <= '0;
			flushing_q <= 1'b0;
		end else if (cfg_we) begin
			size_q     <= size_n;
			row_q      <= '0;
			col_q      <= '0;
			flushing_q <= 1'b0;
		end else if (acc && eff0) begin
			if (c0_ext == size_m1) begin
				col_q <= '0;
				if (flushing_q) begin
					flushing_q <= 1'b0;
					row_q      <= '0;
				end else if (row_q + SW'(1) == size_q) begin
					flushing_q <= 1'b1;
					row_q      <= size_q;
				end else begin
					row_q <= row_q + SW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---- row memory: read at accept, write back from stage 1
	assign mem_re = acc && eff0;
	assign mem_we = s1_adv && valid_s1 && !flush_s1;

	always_ff @(posedge clk) begin
		if (mem_re)
			rd_s1 <= row_mem[col_q];
		if (mem_we)
			row_mem[c_s1] <= {rd_s1[PW-1:0], pix_s1};
	end

	// ---- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_adv)
			valid_s1 <= acc && eff0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			flush_s1 <= action;
			c_s1     <= col_q;
			pix_s1   <= pix_n;
			rec1_s1  <= rec1_n;
			rec2_s1  <= rec2_n;
		end
	end

	// ---- stage 2: shift the window, issue one or two result requests
	always_comb begin
		rec1_go       = rec1_s1;
		rec1_go.valid = valid_s1 && rec1_s1.valid;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= rd_s1[2*PW-1:PW];
			win_q[1][2] <= rd_s1[PW-1:0];
			win_q[2][2] <= pix_s1;
		end
		if (s1_adv)
			rec2_q <= rec2_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_s2  <= '0;
			pend2_q <= 1'b0;
		end else if (en) begin
			if (pend2_q) begin
				// hold stage 1, send the row-end result from the same window
				rec_s2  <= rec2_q;
				pend2_q <= 1'b0;
			end else begin
				rec_s2  <= rec1_go;
				pend2_q <= valid_s1 && rec2_s1.valid;
			end
		end
	end

	bb33_mean #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.rec       (rec_s2),
		.win       (win_q),
		.beat_valid(beat_valid),
		.beat_pos  (beat_pos),
		.beat_ch   (beat_ch)
	);

	// ---- output register with one-beat skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en && beat_valid) begin
			if (!res_valid || res_ready)
				res_valid <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (skid_valid_q && res_ready) begin
			skid_valid_q <= 1'b0;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && beat_valid) begin
			if (!res_valid || res_ready) begin
				{alpha_out, blue_out, green_out, red_out} <= beat_ch;
				{out_row, out_column, frame_end}          <= beat_pos;
			end else begin
				skid_ch_q  <= beat_ch;
				skid_pos_q <= beat_pos;
			end
		end else if (skid_valid_q && res_ready) begin
			{alpha_out, blue_out, green_out, red_out} <= skid_ch_q;
			{out_row, out_column, frame_end}          <= skid_pos_q;
		end
	end

	// ---- assertions
	`ASSERT_IMP(a_skid_has_out, clk, arst_n, skid_valid_q, res_valid)
	`ASSERT_IMP(a_col_in_frame, clk, arst_n, 1'b1, SW'(col_q) < size_q)
	`ASSERT_IMP(a_flush_row, clk, arst_n, flushing_q, row_q == size_q)
	`ASSERT_NEVER(a_mem_same_entry, clk, arst_n, mem_re && mem_we && (col_q == c_s1))

endmodule

// ===== dv/tb_box_blur_3x3_rgba_top.sv =====
// ---------------------------------------------------------------------------
// tb_box_blur_3x3_rgba_top
// Self-checking bench for the 3x3 RGBA box blur. A short table of beats
// covers the smallest image, ignored beats and a 3x3 image. Random frames of
// many sizes follow, with noise beats, cut frames, one long row at the
// largest size, and random stalls on both channels. Every result is
// compared with a table entry or a cycle-free model of the filter in this bench.
// ---------------------------------------------------------------------------
module tb_box_blur_3x3_rgba_top;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam int ITEM_TARGET    = 1850;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic                      act;
		logic [bb33_pkg::CH_W-1:0] red;
		logic [bb33_pkg::CH_W-1:0] green;
		logic [bb33_pkg::CH_W-1:0] blue;
		logic [bb33_pkg::CH_W-1:0] alpha;
	} px_beat_t;

	typedef struct packed {
		logic [bb33_pkg::CH_W-1:0]  red;
		logic [bb33_pkg::CH_W-1:0]  green;
		logic [bb33_pkg::CH_W-1:0]  blue;
		logic [bb33_pkg::CH_W-1:0]  alpha;
		logic [bb33_pkg::POS_W-1:0] row;
		logic [bb33_pkg::POS_W-1:0] col;
		logic                       fe;
	} blur_px_t;

	typedef enum bit {STEP_BEAT, STEP_SIZE} step_kind_t;

	typedef struct packed {
		step_kind_t                 kind;
		logic [bb33_pkg::CFG_W-1:0] size_val;
		px_beat_t                   beat;
		bit                         typed;
		bit [1:0]                   nres;
	} step_t;

	localparam px_beat_t NO_BEAT = '{ACT_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0};

	// a 2x2 image averages all four pixels at every position
	localparam blur_px_t TYPED_MEANS [4] = '{
		'{16'hFFFF, 16'h0000, 16'h3FFF, 16'h0003, 10'd0, 10'd0, 1'b0},
		'{16'hFFFF, 16'h0000, 16'h3FFF, 16'h0003, 10'd0, 10'd1, 1'b0},
		'{16'hFFFF, 16'h0000, 16'h3FFF, 16'h0003, 10'd1, 10'd0, 1'b0},
		'{16'hFFFF, 16'h0000, 16'h3FFF, 16'h0003, 10'd1, 10'd1, 1'b1}
	};

	localparam step_t DIRECTED_STEPS [22] = '{
		'{STEP_BEAT, 11'd0, '{ACT_FLUSH, 16'h1234, 16'h0, 16'h0, 16'h0}, 1'b1, 2'd0},
		'{STEP_SIZE, 11'd1, NO_BEAT, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h0, 16'hFFFF, 16'h1}, 1'b1, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h0, 16'h0, 16'h2}, 1'b1, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h0, 16'h0, 16'h3}, 1'b1, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h0, 16'h0, 16'h7}, 1'b1, 2'd2},
		'{STEP_BEAT, 11'd0, '{ACT_FLUSH, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_FLUSH, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0}, 1'b1, 2'd2},
		'{STEP_SIZE, 11'd3, NO_BEAT, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h5555, 16'h0000, 16'h0001}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'hAAAA, 16'hFFFF, 16'hFFFF}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0002}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h8001, 16'h0000, 16'hFFFE}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_PIXEL, 16'hFFFF, 16'h7FFE, 16'hFFFF, 16'h1234}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_FLUSH, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_FLUSH, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, 2'd0},
		'{STEP_BEAT, 11'd0, '{ACT_FLUSH, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, 2'd0}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [bb33_pkg::CFG_W-1:0] cfg_wdata;
	logic                       pix_valid;
	logic                       pix_ready;
	logic                       action;
	logic [bb33_pkg::CH_W-1:0]  red_in;
	logic [bb33_pkg::CH_W-1:0]  green_in;
	logic [bb33_pkg::CH_W-1:0]  blue_in;
	logic [bb33_pkg::CH_W-1:0]  alpha_in;
	logic                       res_valid;
	logic                       res_ready;
	logic [bb33_pkg::CH_W-1:0]  red_out;
	logic [bb33_pkg::CH_W-1:0]  green_out;
	logic [bb33_pkg::CH_W-1:0]  blue_out;
	logic [bb33_pkg::CH_W-1:0]  alpha_out;
	logic [bb33_pkg::POS_W-1:0] out_row;
	logic [bb33_pkg::POS_W-1:0] out_column;
	logic                       frame_end;

	// filter state as seen from outside
	logic [bb33_pkg::CFG_W-1:0] frame_size;
	logic [63:0]      upper_rows [bb33_pkg::MAX_SIZE_DEF];
	logic [63:0]      middle_rows [bb33_pkg::MAX_SIZE_DEF];
	logic [63:0]      win [3][3];
	int               row_pos;
	int               col_pos;
	bit               in_flush;

	blur_px_t pending_means [$];
	blur_px_t step_means [2];
	int       mismatches;
	int       fed_items;
	int       typed_pos;
	int       quiet_cycles;
	bit       src_burst;
	bit       snk_burst;

	box_blur_3x3_rgba_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int eff_size();
		if (frame_size < 2) return 2;
		if (frame_size > bb33_pkg::MAX_SIZE_DEF) return int'(bb33_pkg::MAX_SIZE_DEF);
		return int'(frame_size);
	endfunction

	function automatic void restart_frame();
		row_pos = 0;
		col_pos = 0;
		in_flush = 1'b0;
		for (int k = 0; k < 3; k++)
			for (int m = 0; m < 3; m++)
				win[k][m] = '0;
	endfunction

	// mean over window rows that fall inside the image, columns mlo..2
	function automatic blur_px_t window_mean(int r, int sz, int mlo, int orow, int ocol);
		int unsigned sum [4] = '{0, 0, 0, 0};
		int unsigned cnt = 0;
		int rr;
		blur_px_t px;
		for (int k = 0; k < 3; k++) begin
			rr = r + k - 2;
			if (rr < 0 || rr > sz - 1) continue;
			for (int m = mlo; m < 3; m++) begin
				for (int ch = 0; ch < 4; ch++)
					sum[ch] += int'(win[k][m][16*ch +: 16]);
				cnt++;
			end
		end
		px.red = bb33_pkg::CH_W'(sum[0] / cnt);
		px.green = bb33_pkg::CH_W'(sum[1] / cnt);
		px.blue = bb33_pkg::CH_W'(sum[2] / cnt);
		px.alpha = bb33_pkg::CH_W'(sum[3] / cnt);
		px.row = bb33_pkg::POS_W'(orow);
		px.col = bb33_pkg::POS_W'(ocol);
		px.fe = (orow == sz - 1) && (ocol == sz - 1);
		return px;
	endfunction

	// advance the filter by one beat; results land in step_means
	function automatic int predict_means(px_beat_t b);
		int sz;
		int r;
		int c;
		int n;
		logic [63:0] pix;
		sz = eff_size();
		n = 0;
		pix = '0;
		if (b.act == ACT_FLUSH) begin
			if (!in_flush) return 0;
			r = sz;
		end else begin
			if (in_flush) return 0;
			r = row_pos;
			pix = {b.alpha, b.blue, b.green, b.red};
		end
		c = (col_pos >= sz) ? sz - 1 : col_pos;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = upper_rows[c];
		win[1][2] = middle_rows[c];
		win[2][2] = pix;
		if (!in_flush) begin
			upper_rows[c] = middle_rows[c];
			middle_rows[c] = pix;
		end
		if (r >= 1 && c >= 1) begin
			step_means[n++] = window_mean(r, sz, (c >= 2) ? 0 : 1, r - 1, c - 1);
			if (c == sz - 1)
				step_means[n++] = window_mean(r, sz, 1, r - 1, c);
		end
		c++;
		if (c >= sz) begin
			c = 0;
			if (in_flush) begin
				in_flush = 1'b0;
				row_pos = 0;
			end else begin
				row_pos++;
				if (row_pos >= sz) begin
					row_pos = sz;
					in_flush = 1'b1;
				end
			end
		end
		col_pos = c;
		return n;
	endfunction

	function automatic logic [bb33_pkg::CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return bb33_pkg::CH_W'($urandom);
		endcase
	endfunction

	function automatic px_beat_t rand_beat(logic act);
		px_beat_t b;
		b.act = act;
		b.red = rand_chan();
		b.green = rand_chan();
		b.blue = rand_chan();
		b.alpha = rand_chan();
		return b;
	endfunction

	task automatic send_beat(input px_beat_t b, input bit typed, input int nres);
		int gap;
		int n;
		gap = src_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		action <= b.act;
		red_in <= b.red;
		green_in <= b.green;
		blue_in <= b.blue;
		alpha_in <= b.alpha;
		do @(posedge clk); while (!pix_ready);
		if ((b.act == ACT_FLUSH) == in_flush)
			fed_items++;
		n = predict_means(b);
		if (typed) begin
			repeat (nres) begin
				pending_means.push_back(TYPED_MEANS[typed_pos]);
				typed_pos++;
			end
		end else begin
			for (int i = 0; i < n; i++)
				pending_means.push_back(step_means[i]);
		end
	endtask

	// write image_size once the pipe has drained; this restarts the frame
	task automatic set_size(input logic [bb33_pkg::CFG_W-1:0] val);
		pix_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_size = val;
		restart_frame();
	endtask

	task automatic run_phase(input logic [bb33_pkg::CFG_W-1:0] val, input int frames);
		int sz;
		int total;
		int cut;
		set_size(val);
		sz = eff_size();
		src_burst = ($urandom_range(0, 3) == 0);
		for (int f = 0; f < frames && fed_items < ITEM_TARGET; f++) begin
			total = sz * sz;
			cut = total;
			if (f == frames - 1 && $urandom_range(0, 5) == 0)
				cut = $urandom_range(1, total - 1);
			for (int i = 0; i < cut && fed_items < ITEM_TARGET; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_beat(rand_beat(ACT_FLUSH), 1'b0, 0);
				send_beat(rand_beat(ACT_PIXEL), 1'b0, 0);
			end
			if (in_flush) begin
				for (int j = 0; j < sz; j++) begin
					if ($urandom_range(0, 7) == 0)
						send_beat(rand_beat(ACT_PIXEL), 1'b0, 0);
					send_beat(rand_beat(ACT_FLUSH), 1'b0, 0);
				end
			end
		end
	endtask

	function automatic logic [bb33_pkg::CFG_W-1:0] pick_size();
		case ($urandom_range(0, 15))
			0: return 11'd0;
			1: return 11'd1;
			2: return 11'd2;
			3: return 11'd3;
			4: return bb33_pkg::CFG_W'($urandom_range(13, 33));
			default: return bb33_pkg::CFG_W'($urandom_range(2, 12));
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		pix_valid <= 1'b0;
		action <= ACT_PIXEL;
		red_in <= '0;
		green_in <= '0;
		blue_in <= '0;
		alpha_in <= '0;
		frame_size = bb33_pkg::CFG_W'(bb33_pkg::IMAGE_SIZE_RESET);
		for (int i = 0; i < bb33_pkg::MAX_SIZE_DEF; i++) begin
			upper_rows[i] = '0;
			middle_rows[i] = '0;
		end
		restart_frame();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_STEPS[i]) begin
			if (DIRECTED_STEPS[i].kind == STEP_SIZE)
				set_size(DIRECTED_STEPS[i].size_val);
			else
				send_beat(DIRECTED_STEPS[i].beat, DIRECTED_STEPS[i].typed,
					DIRECTED_STEPS[i].nres);
		end

		// one full row at the clamped top size, then the head of the next
		set_size(11'h7FF);
		src_burst = 1'b1;
		repeat (bb33_pkg::MAX_SIZE_DEF + 10) send_beat(rand_beat(ACT_PIXEL), 1'b0, 0);
		set_size(bb33_pkg::CFG_W'(bb33_pkg::MAX_SIZE_DEF));
		src_burst = 1'b0;
		repeat (20) send_beat(rand_beat(ACT_PIXEL), 1'b0, 0);

		while (fed_items < ITEM_TARGET)
			run_phase(pick_size(), $urandom_range(1, 3));

		pix_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_means.size() == 0)
			$display("box_blur_3x3_rgba_top: match");
		else
			$display("box_blur_3x3_rgba_top: mismatch");
		$finish;
	end

	// result side: random stalls, with long stretches of no stall
	initial begin
		int gap;
		res_ready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = snk_burst ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			if ($urandom_range(0, 63) == 0)
				snk_burst = ~snk_burst;
		end
	end

	always @(posedge clk) begin
		blur_px_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_means.size() == 0) begin
				$error("result beat with none expected: row %0d column %0d",
					out_row, out_column);
				mismatches++;
			end else begin
				want = pending_means.pop_front();
				if (red_out !== want.red) begin
					$error("red_out: expected %h, got %h", want.red, red_out);
					mismatches++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %h, got %h", want.green, green_out);
					mismatches++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %h, got %h", want.blue, blue_out);
					mismatches++;
				end
				if (alpha_out !== want.alpha) begin
					$error("alpha_out: expected %h, got %h", want.alpha, alpha_out);
					mismatches++;
				end
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					mismatches++;
				end
				if (out_column !== want.col) begin
					$error("out_column: expected %0d, got %0d", want.col, out_column);
					mismatches++;
				end
				if (frame_end !== want.fe) begin
					$error("frame_end: expected %b, got %b", want.fe, frame_end);
					mismatches++;
				end
			end
		end
	end

	// end the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (res_valid && res_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("box_blur_3x3_rgba_top: mismatch");
			$finish;
		end
	end

endmodule
